// ===== src/ssp_pkg.sv =====
package ssp_pkg;

   localparam logic [8:0]  NODE_COUNT_RESET = 9'd256;
   localparam logic [23:0] DIST_SAT = 24'hFFFFFF;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  from_node;
      logic [7:0]  to_node;
      logic [15:0] weight;
      logic [7:0]  label;
   } edge_type;

   typedef enum logic [3:0] {
      ST_BOOT,
      ST_IDLE,
      ST_CLEAR,
      ST_ADD,
      ST_RUN_INIT,
      ST_SCAN,
      ST_SETTLE,
      ST_LIST,
      ST_EFETCH,
      ST_EDGE,
      ST_NODE,
      ST_QRY,
      ST_QRY_PRED,
      ST_RESP
   } state_type;

endpackage

// ===== src/ssp_channels.sv =====
interface ssp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  edge_from;
   logic [7:0]  edge_to;
   logic [15:0] edge_dist;
   logic [7:0]  edge_label;
   logic [7:0]  start_node;
   logic [7:0]  query_node;

   modport source(output valid, action, edge_from, edge_to, edge_dist, edge_label,
                  start_node, query_node, input ready);
   modport sink(input valid, action, edge_from, edge_to, edge_dist, edge_label,
                start_node, query_node, output ready);
endinterface

interface ssp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [23:0] node_distance;
   logic        node_reached;
   logic        has_pred;
   logic [7:0]  pred_node;
   logic [7:0]  pred_label;

   modport source(output valid, status, node_distance, node_reached, has_pred,
                  pred_node, pred_label, input ready);
   modport sink(input valid, status, node_distance, node_reached, has_pred,
                pred_node, pred_label, output ready);
endinterface

// ===== src/ssp_ram.sv =====
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/single_source_shortest_path.sv =====
// Shortest-path engine: edges are added one beat at a time into per-source
// lists held in memory, a run computes distances from a start node, and a
// read beat returns one node's distance, reach flag and predecessor edge.
// Every request beat yields exactly one response beat. After reset the block
// clears its node memories before taking a request, and a clear request
// clears them too. A run first clears the results, then for every settled
// node scans the node memory, marks the node and fetches its list, and
// visits each outgoing edge, reading the target node when it is in range;
// a last scan finds no node left and ends the run. The node memory has a
// single read port.
module single_source_shortest_path #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   ssp_req_if.sink    req_ch,
   ssp_rsp_if.source  rsp_ch
);
   import ssp_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int CW  = (NCW > 9) ? NCW : 9;
   localparam int CEW = $clog2(MAX_EDGES + 1);
   localparam int NDW = 27 + EW;
   localparam int LW  = 1 + 2 * EW;
   localparam int B_REACH = NDW - 1;
   localparam int B_SETTL = NDW - 2;
   localparam int B_PVAL  = NDW - 3;
   localparam int B_DIST  = NDW - 4;

   function automatic logic [NW-1:0] node_addr(input logic [7:0] x);
      logic [NW+7:0] w;
      w = {{NW{1'b0}}, x};
      return w[NW-1:0];
   endfunction

   function automatic logic [CW-1:0] node_ext(input logic [7:0] x);
      return {{(CW-8){1'b0}}, x};
   endfunction

   state_type       state_ff, state_in;
   logic [8:0]      csr_node_count_ff;
   logic [CW-1:0]   n_cnt, csr_ext;
   logic [CEW-1:0]  edge_total_ff, edge_total_in;
   logic [CW-1:0]   sw_ff, sw_in, v_ff, v_in;
   logic            pipe_vld_ff, pipe_vld_in;
   logic [NW-1:0]   pipe_idx_ff, pipe_idx_in;
   logic            found_ff, found_in;
   logic [NDW-1:0]  best_ff, best_in;
   logic [NW-1:0]   best_idx_ff, best_idx_in;
   logic [23:0]     ud_ff, ud_in;
   logic [EW-1:0]   e_ff, e_in, tail_ff, tail_in, nxt_ff, nxt_in;
   logic [NW-1:0]   t_ff, t_in;
   logic [15:0]     w_ff, w_in;
   logic [7:0]      from_ff, from_in, start_ff, start_in;
   logic [1:0]      res_status_ff, res_status_in;
   logic [23:0]     res_dist_ff, res_dist_in;
   logic            res_reach_ff, res_reach_in, res_pred_ff, res_pred_in;
   logic [7:0]      res_pnode_ff, res_pnode_in, res_plabel_ff, res_plabel_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff;
   logic [23:0]     rsp_dist_ff;
   logic            rsp_reach_ff, rsp_pred_ff;
   logic [7:0]      rsp_pnode_ff, rsp_plabel_ff;
   logic            rsp_load;

   logic            edge_we;
   logic [EW-1:0]   edge_wa, edge_ra;
   edge_type        edge_wd, edge_rd;
   logic            next_we;
   logic [EW-1:0]   next_wa, next_wd, next_rd;
   logic            node_we;
   logic [NW-1:0]   node_wa, node_ra;
   logic [NDW-1:0]  node_wd, node_rd;
   logic            list_we;
   logic [NW-1:0]   list_wa, list_ra;
   logic [LW-1:0]   list_wd, list_rd;

   logic            accept;
   logic [24:0]     sum;
   logic [23:0]     nd;
   logic [NDW-1:0]  start_word;

   ssp_ram #(.WIDTH($bits(edge_type)), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd)
   );

   ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(edge_ra), .rd_data(next_rd)
   );

   ssp_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd)
   );

   ssp_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_list_ram (
      .clock(clock), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_addr(list_ra), .rd_data(list_rd)
   );

   assign csr_ext = CW'(csr_node_count_ff);
   assign n_cnt = (csr_node_count_ff == 9'd0) ? CW'(1) :
                  (csr_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : csr_ext;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign sum = {1'b0, ud_ff} + {9'd0, w_ff};
   assign nd  = sum[24] ? DIST_SAT : sum[23:0];
   assign start_word = {1'b1, {(NDW-1){1'b0}}};

   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      sw_in         = sw_ff;
      v_in          = v_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      ud_in         = ud_ff;
      e_in          = e_ff;
      tail_in       = tail_ff;
      nxt_in        = nxt_ff;
      t_in          = t_ff;
      w_in          = w_ff;
      from_in       = from_ff;
      start_in      = start_ff;
      res_status_in = res_status_ff;
      res_dist_in   = res_dist_ff;
      res_reach_in  = res_reach_ff;
      res_pred_in   = res_pred_ff;
      res_pnode_in  = res_pnode_ff;
      res_plabel_in = res_plabel_ff;
      rsp_load      = 1'b0;
      edge_we = 1'b0;
      edge_wa = edge_total_ff[EW-1:0];
      edge_wd = '0;
      edge_ra = e_ff;
      next_we = 1'b0;
      next_wa = tail_ff;
      next_wd = edge_total_ff[EW-1:0];
      node_we = 1'b0;
      node_wa = t_ff;
      node_wd = '0;
      node_ra = '0;
      list_we = 1'b0;
      list_wa = sw_ff[NW-1:0];
      list_wd = '0;
      list_ra = node_addr(from_ff);

      case (state_ff)
         ST_BOOT, ST_CLEAR: begin
            node_we = 1'b1;
            node_wa = sw_ff[NW-1:0];
            list_we = 1'b1;
            sw_in   = sw_ff + CW'(1);
            if (sw_ff == CW'(MAX_NODES - 1)) begin
               state_in = (state_ff == ST_BOOT) ? ST_IDLE : ST_RESP;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_status_in = STATUS_OK;
               res_dist_in   = '0;
               res_reach_in  = 1'b0;
               res_pred_in   = 1'b0;
               res_pnode_in  = '0;
               res_plabel_in = '0;
               from_in       = req_ch.edge_from;
               start_in      = req_ch.start_node;
               sw_in         = '0;
               case (action_type'(req_ch.action))
                  ACT_CLEAR: begin
                     edge_total_in = '0;
                     state_in      = ST_CLEAR;
                  end
                  ACT_ADD: begin
                     if (node_ext(req_ch.edge_from) >= n_cnt ||
                         node_ext(req_ch.edge_to) >= n_cnt) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_RESP;
                     end else if (edge_total_ff == CEW'(MAX_EDGES)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_RESP;
                     end else begin
                        edge_we  = 1'b1;
                        edge_wd  = '{from_node: req_ch.edge_from, to_node: req_ch.edge_to,
                                     weight: req_ch.edge_dist, label: req_ch.edge_label};
                        list_ra  = node_addr(req_ch.edge_from);
                        state_in = ST_ADD;
                     end
                  end
                  ACT_RUN: begin
                     if (node_ext(req_ch.start_node) >= n_cnt) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_RUN_INIT;
                     end
                  end
                  default: begin
                     if (node_ext(req_ch.query_node) >= n_cnt) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_RESP;
                     end else begin
                        node_ra  = node_addr(req_ch.query_node);
                        state_in = ST_QRY;
                     end
                  end
               endcase
            end
         end
         ST_ADD: begin
            list_we = 1'b1;
            list_wa = node_addr(from_ff);
            if (list_rd[LW-1]) begin
               next_we = 1'b1;
               next_wa = list_rd[EW-1:0];
               list_wd = {1'b1, list_rd[2*EW-1:EW], edge_total_ff[EW-1:0]};
            end else begin
               list_wd = {1'b1, edge_total_ff[EW-1:0], edge_total_ff[EW-1:0]};
            end
            edge_total_in = edge_total_ff + CEW'(1);
            state_in      = ST_RESP;
         end
         ST_RUN_INIT: begin
            node_we = 1'b1;
            node_wa = sw_ff[NW-1:0];
            node_wd = (sw_ff[NW-1:0] == node_addr(start_ff)) ? start_word : '0;
            sw_in   = sw_ff + CW'(1);
            if (sw_ff == CW'(MAX_NODES - 1)) begin
               v_in     = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            node_ra = v_ff[NW-1:0];
            if (v_ff < n_cnt) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = v_ff[NW-1:0];
               v_in        = v_ff + CW'(1);
            end
            if (pipe_vld_ff && node_rd[B_REACH] && !node_rd[B_SETTL] &&
                (!found_ff || node_rd[B_DIST -: 24] < best_ff[B_DIST -: 24])) begin
               found_in    = 1'b1;
               best_in     = node_rd;
               best_idx_in = pipe_idx_ff;
            end
            if (!(v_ff < n_cnt) && !pipe_vld_ff) begin
               state_in = found_ff ? ST_SETTLE : ST_RESP;
            end
         end
         ST_SETTLE: begin
            node_we  = 1'b1;
            node_wa  = best_idx_ff;
            node_wd  = best_ff;
            node_wd[B_SETTL] = 1'b1;
            list_ra  = best_idx_ff;
            ud_in    = best_ff[B_DIST -: 24];
            state_in = ST_LIST;
         end
         ST_LIST: begin
            v_in     = '0;
            found_in = 1'b0;
            if (list_rd[LW-1]) begin
               e_in     = list_rd[2*EW-1:EW];
               tail_in  = list_rd[EW-1:0];
               state_in = ST_EFETCH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_EFETCH: begin
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            nxt_in = next_rd;
            w_in   = edge_rd.weight;
            t_in   = node_addr(edge_rd.to_node);
            if (node_ext(edge_rd.to_node) < n_cnt) begin
               node_ra  = node_addr(edge_rd.to_node);
               state_in = ST_NODE;
            end else if (e_ff == tail_ff) begin
               v_in     = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               e_in     = next_rd;
               state_in = ST_EFETCH;
            end
         end
         ST_NODE: begin
            if (!node_rd[B_REACH] || nd < node_rd[B_DIST -: 24]) begin
               node_we = 1'b1;
               node_wa = t_ff;
               node_wd = {1'b1, node_rd[B_SETTL], 1'b1, nd, e_ff};
            end
            if (e_ff == tail_ff) begin
               v_in     = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               e_in     = nxt_ff;
               state_in = ST_EFETCH;
            end
         end
         ST_QRY: begin
            edge_ra  = node_rd[EW-1:0];
            state_in = ST_RESP;
            if (node_rd[B_REACH]) begin
               res_dist_in  = node_rd[B_DIST -: 24];
               res_reach_in = 1'b1;
               if (node_rd[B_PVAL]) begin
                  state_in = ST_QRY_PRED;
               end
            end
         end
         ST_QRY_PRED: begin
            res_pred_in   = 1'b1;
            res_pnode_in  = edge_rd.from_node;
            res_plabel_in = edge_rd.label;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_BOOT;
         csr_node_count_ff <= NODE_COUNT_RESET;
         edge_total_ff     <= '0;
         sw_ff             <= '0;
         pipe_vld_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         sw_ff         <= sw_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      pipe_idx_ff   <= pipe_idx_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      ud_ff         <= ud_in;
      e_ff          <= e_in;
      tail_ff       <= tail_in;
      nxt_ff        <= nxt_in;
      t_ff          <= t_in;
      w_ff          <= w_in;
      from_ff       <= from_in;
      start_ff      <= start_in;
      res_status_ff <= res_status_in;
      res_dist_ff   <= res_dist_in;
      res_reach_ff  <= res_reach_in;
      res_pred_ff   <= res_pred_in;
      res_pnode_ff  <= res_pnode_in;
      res_plabel_ff <= res_plabel_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_dist_ff   <= res_dist_ff;
         rsp_reach_ff  <= res_reach_ff;
         rsp_pred_ff   <= res_pred_ff;
         rsp_pnode_ff  <= res_pnode_ff;
         rsp_plabel_ff <= res_plabel_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.node_distance = rsp_dist_ff;
   assign rsp_ch.node_reached  = rsp_reach_ff;
   assign rsp_ch.has_pred      = rsp_pred_ff;
   assign rsp_ch.pred_node     = rsp_pnode_ff;
   assign rsp_ch.pred_label    = rsp_plabel_ff;

   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= CEW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !node_we)
      else $error("node memory written during minimum scan");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response beat raised outside response state");

   a_settle_marks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETTLE |-> node_we && node_wd[B_SETTL] && found_ff)
      else $error("settle step did not mark the chosen node");

endmodule
